@@ rtl/fir_filter_stereo_core_defines.svh @@
// Assertion macros shared by the FIR filter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FIR_FILTER_STEREO_CORE_DEFINES_SVH
`define FIR_FILTER_STEREO_CORE_DEFINES_SVH

// Check sampled on the clock, masked while reset is high.
`define FFS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check sampled on the clock, active through reset as well.
`define FFS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ rtl/ffs_pkg.sv @@
// Package for the stereo FIR filter: sizes, widths, types and sequencer states.
// No dependencies.
`default_nettype none

package ffs_pkg;

   // filter geometry
   localparam int TAPS         = 8;
   localparam int NUM_COEFS    = 8;
   localparam int NUM_CHANNELS = 2;
   localparam int TAP_W        = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int COEF_IDX_W   = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;

   // data widths
   localparam int SAMPLE_W  = 16;
   localparam int CSR_IDX_W = 8;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int ACC_W     = PROD_W + TAP_W;
   localparam int FRAC_BITS = 15;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   // coefficient reset: tap 0 passes the sample at about unity gain
   localparam sample_type COEF0_RESET = 16'sh7FFF;
   localparam sample_type SAMPLE_MAX  = 16'sh7FFF;
   localparam sample_type SAMPLE_MIN  = -16'sh8000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } ffs_state_type;

endpackage

`default_nettype wire

@@ rtl/fir_filter_stereo_core.sv @@
// Stereo direct-form FIR filter top level: history, one shared MAC, round/saturate.
// Depends on ffs_pkg and fir_filter_stereo_core_defines.svh.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | sample_in, channel_in, clear_history
//   rsp     | out       | rsp_valid/rsp_stall  | filtered_sample, channel_out, saturated
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata (coef_0..coef_7)
//
// A request runs through the states MAC, with one multiply per tap through a
// single 16x16 multiplier, DRAIN, which adds the last product, and DONE, which rounds.
// req_stall is high while a request is in work; the result waits in an output
// register, and the next request is taken as soon as the result has been loaded.
// Reset clears the histories, the output valid and coef_1..coef_7; coef_0 gets COEF0_RESET.
`default_nettype none
`include "fir_filter_stereo_core_defines.svh"

module fir_filter_stereo_core
   import ffs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [15:0]   sample_in,
   input  wire logic                 channel_in,
   input  wire logic                 clear_history,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [15:0]        filtered_sample,
   output logic                      channel_out,
   output logic                      saturated,
   // register writes
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata
);

   localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1 << (FRAC_BITS - 1));
   localparam int YW = ACC_W + 1 - FRAC_BITS;
   localparam logic signed [YW-1:0] Y_MAX = YW'(SAMPLE_MAX);
   localparam logic signed [YW-1:0] Y_MIN = YW'(SAMPLE_MIN);

   ffs_state_type state_ff, state_in;

   sample_type coef_ff [NUM_COEFS];
   sample_type hist_ff [NUM_CHANNELS][TAPS];

   logic [TAP_W-1:0] tap_ff, tap_in;
   logic             chan_ff;
   prod_type         prod_ff;
   acc_type          acc_ff;

   logic             rsp_valid_ff;
   sample_type       rsp_sample_ff;
   logic             rsp_chan_ff;
   logic             rsp_sat_ff;

   logic             req_take;
   logic             rsp_load;
   logic             out_free;

   logic signed [ACC_W:0] rnd_sum;
   logic signed [YW-1:0]  y_full;
   sample_type            y_sat;
   logic                  y_clip;

   // configuration: always ready, writes beyond the coefficient list are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= (i == 0) ? COEF0_RESET : '0;
         end
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_COEFS))) begin
         coef_ff[csr_index[COEF_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      req_stall = 1'b1;
      req_take  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_take = 1'b1;
               tap_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (tap_ff == TAP_W'(TAPS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // per-channel history: newest at entry 0, optional clear before the shift
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            for (int k = 0; k < TAPS; k++) begin
               hist_ff[c][k] <= '0;
            end
         end
      end else if (req_take) begin
         hist_ff[channel_in][0] <= sample_in;
         for (int k = 1; k < TAPS; k++) begin
            hist_ff[channel_in][k] <= clear_history ? '0 : hist_ff[channel_in][k-1];
         end
      end
   end

   // shared MAC: product registered, then accumulated the next cycle
   always_ff @(posedge clock) begin
      if (req_take) begin
         chan_ff <= channel_in;
         prod_ff <= '0;
         acc_ff  <= '0;
      end else if (state_ff == ST_MAC) begin
         prod_ff <= coef_ff[COEF_IDX_W'(tap_ff)] * hist_ff[chan_ff][tap_ff];
         acc_ff  <= acc_ff + ACC_W'(prod_ff);
      end else if (state_ff == ST_DRAIN) begin
         acc_ff  <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // round half up, then clip to 16 bits
   always_comb begin
      rnd_sum = (ACC_W+1)'(acc_ff) + RND_HALF;
      y_full  = rnd_sum[ACC_W:FRAC_BITS];
      y_clip  = 1'b0;
      priority if (y_full > Y_MAX) begin
         y_sat  = SAMPLE_MAX;
         y_clip = 1'b1;
      end else if (y_full < Y_MIN) begin
         y_sat  = SAMPLE_MIN;
         y_clip = 1'b1;
      end else begin
         y_sat  = y_full[SAMPLE_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= y_sat;
         rsp_chan_ff   <= chan_ff;
         rsp_sat_ff    <= y_clip;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign filtered_sample = rsp_sample_ff;
   assign channel_out     = rsp_chan_ff;
   assign saturated       = rsp_sat_ff;

   // checks
   `FFS_ASSERT(a_take_starts_mac, req_valid && !req_stall |=> state_ff == ST_MAC, "request taken but MAC not started")
   `FFS_ASSERT(a_drain_after_last_tap, state_ff == ST_DRAIN |-> $past(state_ff) == ST_MAC && $past(tap_ff) == TAP_W'(TAPS - 1), "drain entered before last tap")
   `FFS_ASSERT(a_sat_at_rail, rsp_valid && saturated |-> filtered_sample == SAMPLE_MAX || filtered_sample == SAMPLE_MIN, "saturated result not at a rail")
   `FFS_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE && !rsp_valid, "reset did not idle the block")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for fir_filter_stereo_core: directed and random sample streams with a
// cycle-free FIR predictor, a scoreboard on the result channel and a stall watchdog.
// Depends on ffs_pkg and the fir_filter_stereo_core RTL.
`timescale 1ns / 100ps

module tb;
   import ffs_pkg::*;

   localparam int FILTER_LATENCY  = TAPS + 3;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int N_PHASES        = 8;
   localparam int PHASE_ITEMS     = 250;

   // coefficient fill patterns for the random phases
   typedef enum int {
      COEF_FULL_RANGE,
      COEF_EXTREMES,
      COEF_GENTLE,
      COEF_ONE_TAP
   } coef_mode_type;

   typedef struct {
      sample_type sample;
      logic       channel;
      logic       sat;
   } filter_out_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   sample_type           sample_in = '0;
   logic                 channel_in = 1'b0;
   logic                 clear_history = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sample_type           filtered_sample;
   logic                 channel_out;
   logic                 saturated;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_wdata = '0;

   // predictor state
   sample_type     coef_regs [NUM_COEFS];
   sample_type     history [NUM_CHANNELS][TAPS];
   sample_type     next_coefs [NUM_COEFS];
   filter_out_type pending_outputs [$];

   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   bit hold_off_pending = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;
   int n_errors = 0;
   int n_items = 0;
   int n_results = 0;
   int n_csr_writes = 0;
   int n_saturated = 0;

   fir_filter_stereo_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .sample_in       (sample_in),
      .channel_in      (channel_in),
      .clear_history   (clear_history),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .filtered_sample (filtered_sample),
      .channel_out     (channel_out),
      .saturated       (saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // shift the sample into its channel history and compute the rounded, clipped sum
   function automatic void predict_fir(sample_type s, logic ch, logic clr);
      longint         acc;
      longint         y;
      filter_out_type want;
      int             k;
      if (clr) begin
         for (k = 0; k < TAPS; k++) history[ch][k] = '0;
      end
      for (k = TAPS - 1; k > 0; k--) history[ch][k] = history[ch][k-1];
      history[ch][0] = s;
      acc = 0;
      for (k = 0; k < TAPS; k++) acc += longint'(coef_regs[k]) * longint'(history[ch][k]);
      // floor after adding half an LSB: exact halves go toward plus infinity
      y = (acc + 64'sd16384) >>> 15;
      want.sat = 1'b0;
      if (y > 32767) begin
         y = 32767;
         want.sat = 1'b1;
      end else if (y < -32768) begin
         y = -32768;
         want.sat = 1'b1;
      end
      want.sample  = sample_type'(y);
      want.channel = ch;
      pending_outputs.push_back(want);
   endfunction

   // valid stays high across back-to-back requests; this task drops it only before a gap
   task automatic send_sample(input sample_type s, input logic ch, input logic clr);
      int gap;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      sample_in     <= s;
      channel_in    <= ch;
      clear_history <= clr;
      do @(posedge clock); while (req_stall);
      predict_fir(s, ch, clr);
      n_items++;
   endtask

   // caller lowers csr_valid after its last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_COEFS) coef_regs[idx] = sample_type'(val);
      n_csr_writes++;
   endtask

   task automatic load_coefs();
      int k;
      for (k = 0; k < NUM_COEFS; k++) write_reg(CSR_IDX_W'(k), next_coefs[k]);
      csr_valid <= 1'b0;
   endtask

   // every request yields one result, so an empty queue means the core is idle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic test_default_coefs();
      send_sample(16'sh7FFF, 1'b0, 1'b0);
      send_sample(-16'sh8000, 1'b1, 1'b0);
      send_sample(16'sh0000, 1'b0, 1'b0);
      send_sample(16'sh0001, 1'b1, 1'b0);
      send_sample(-16'sh0001, 1'b0, 1'b1);
      send_sample(-16'sh8000, 1'b0, 1'b0);
   endtask

   // coef_0 = one LSB: the output is sample / 2^15 rounded half up
   task automatic test_rounding();
      int k;
      wait_idle();
      for (k = 0; k < NUM_COEFS; k++) next_coefs[k] = '0;
      next_coefs[0] = 16'sh0001;
      load_coefs();
      send_sample(16'sh4000, 1'b0, 1'b0);
      send_sample(-16'sh4000, 1'b1, 1'b0);
      send_sample(16'sh3FFF, 1'b0, 1'b0);
      send_sample(-16'sh4001, 1'b1, 1'b0);
   endtask

   task automatic test_saturation();
      int k;
      wait_idle();
      for (k = 0; k < NUM_COEFS; k++) next_coefs[k] = -16'sh8000;
      load_coefs();
      send_sample(-16'sh8000, 1'b0, 1'b1);
      send_sample(16'sh7FFF, 1'b0, 1'b0);
      wait_idle();
      for (k = 0; k < NUM_COEFS; k++) next_coefs[k] = 16'sh7FFF;
      load_coefs();
      send_sample(16'sh7FFF, 1'b1, 1'b1);
      send_sample(-16'sh8000, 1'b0, 1'b1);
   endtask

   // writes beyond the last coefficient must leave the filter untouched
   task automatic test_csr_index_range();
      wait_idle();
      write_reg(CSR_IDX_W'(NUM_COEFS), 16'h1234);
      write_reg(8'h80, 16'h8000);
      write_reg(8'hFF, 16'hFFFF);
      csr_valid <= 1'b0;
      send_sample(16'sh1234, 1'b0, 1'b0);
      send_sample(-16'sh0F0F, 1'b1, 1'b0);
   endtask

   // interleaved channels, clearing only one of them
   task automatic test_channel_isolation();
      wait_idle();
      next_coefs = '{16'sh2000, -16'sh2000, 16'sh1000, 16'sh0800,
                     -16'sh0400, 16'sh0200, 16'sh0100, -16'sh0080};
      load_coefs();
      send_sample(16'sh4000, 1'b0, 1'b0);
      send_sample(-16'sh4000, 1'b1, 1'b0);
      send_sample(16'sh1000, 1'b0, 1'b0);
      send_sample(16'sh2000, 1'b1, 1'b1);
      send_sample(16'sh7FFF, 1'b0, 1'b0);
      send_sample(-16'sh8000, 1'b1, 1'b0);
   endtask

   // receiver holds off while requests keep coming, so the core backs up
   task automatic test_back_pressure();
      int i;
      wait_idle();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_off_pending = 1'b1;
      for (i = 0; i < 12; i++)
         send_sample(sample_type'($urandom_range(0, 65535)), 1'(i % 2), 1'b0);
   endtask

   task automatic test_random_streams();
      int            phase;
      int            i;
      int            k;
      int            pick;
      coef_mode_type mode;
      sample_type    s;
      for (phase = 0; phase < N_PHASES; phase++) begin
         wait_idle();
         mode = coef_mode_type'(phase % 4);
         for (k = 0; k < NUM_COEFS; k++) begin
            case (mode)
               COEF_FULL_RANGE: next_coefs[k] = sample_type'($urandom_range(0, 65535));
               COEF_EXTREMES: next_coefs[k] = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
               COEF_GENTLE: next_coefs[k] = sample_type'(int'($urandom_range(0, 8191)) - 4096);
               default: next_coefs[k] = '0;
            endcase
         end
         if (mode == COEF_ONE_TAP)
            next_coefs[$urandom_range(0, NUM_COEFS - 1)] = sample_type'($urandom_range(0, 65535));
         load_coefs();
         req_idle_on = (phase != 0) && (phase != 5);
         rsp_idle_on = (phase != 0) && (phase != 3);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               s = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
            else if (pick == 1)
               s = sample_type'(int'($urandom_range(0, 16)) - 8);
            else
               s = sample_type'($urandom_range(0, 65535));
            send_sample(s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 31) == 0));
         end
      end
   endtask

   // receiver stalls: random bursts plus the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap(1'b1);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // scoreboard: each result against the oldest prediction
   always @(posedge clock) begin : check_outputs
      filter_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_outputs.size() == 0) begin
            $error("result with nothing pending: filtered_sample %0d channel_out %0d",
                   filtered_sample, channel_out);
            n_errors++;
         end else begin
            want = pending_outputs.pop_front();
            if (want.sat) n_saturated++;
            if (filtered_sample !== want.sample) begin
               $error("filtered_sample: expected %0d, got %0d", want.sample, filtered_sample);
               n_errors++;
            end
            if (channel_out !== want.channel) begin
               $error("channel_out: expected %0d, got %0d", want.channel, channel_out);
               n_errors++;
            end
            if (saturated !== want.sat) begin
               $error("saturated: expected %0d, got %0d", want.sat, saturated);
               n_errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles, %0d results outstanding",
                   idle_cycles, pending_outputs.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int k;
      for (k = 0; k < NUM_COEFS; k++) coef_regs[k] = '0;
      coef_regs[0] = COEF0_RESET;
      for (k = 0; k < TAPS; k++) begin
         history[0][k] = '0;
         history[1][k] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_default_coefs();
      test_rounding();
      test_saturation();
      test_csr_index_range();
      test_channel_isolation();
      test_back_pressure();
      test_random_streams();

      wait_idle();
      repeat (2 * FILTER_LATENCY) @(posedge clock);
      $display("Ran %0d samples over both channels, %0d results, %0d saturated.",
               n_items, n_results, n_saturated);
      $display("Covered %0d register writes, rounding, clipping, clears, back-pressure.",
               n_csr_writes);
      if (n_errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
